// File: rtl/core/sebin_pkg.sv
// ----------------------------------------------------------------------------
// sebin_pkg
// Shared widths, register indexes, constants and types of the Sobel edge
// binarizer.
// ----------------------------------------------------------------------------
package sebin_pkg;

   localparam int PIX_W      = 8;
   localparam int FW_W       = 11;
   localparam int FH_W       = 16;
   localparam int THR_W      = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_DIM           = 3;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0]  FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [THR_W-1:0] EDGE_THR_RESET     = 21'd65025;

   localparam logic [PIX_W-1:0] LEVEL_EDGE  = 8'd0;
   localparam logic [PIX_W-1:0] LEVEL_WHITE = 8'd255;

   // (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
   localparam int               SUM_W      = 10;
   localparam logic [SUM_W-1:0] GREY_RECIP = 10'd683;
   localparam int               GREY_SHIFT = 11;

   localparam int GRAD_W = 11;   // signed Sobel gradient
   localparam int MAG_W  = 21;   // gx*gx + gy*gy

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_EDGE_THR     = 2'd2
   } csr_index_type;

   // one new window column: two older rows from the line stores, newest grey
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } sebin_col_type;

endpackage

// File: rtl/core/sebin_line_buffer.sv
// ----------------------------------------------------------------------------
// sebin_line_buffer
// Two line stores kept side by side in one memory word, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
module sebin_line_buffer #(
   parameter int MAX_WIDTH = sebin_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic [sebin_pkg::PIX_W-1:0]  rd_top,
   output logic [sebin_pkg::PIX_W-1:0]  rd_mid,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [sebin_pkg::PIX_W-1:0]  wr_top,
   input  logic [sebin_pkg::PIX_W-1:0]  wr_mid
);

   localparam int PW = sebin_pkg::PIX_W;

   // word = {older row, previous row}
   logic [2*PW-1:0] mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= {wr_top, wr_mid};
      end
   end

   assign rd_top = rd_data_ff[2*PW-1:PW];
   assign rd_mid = rd_data_ff[PW-1:0];

endmodule

// File: rtl/core/sebin_window.sv
// ----------------------------------------------------------------------------
// sebin_window
// 3x3 pixel window with Sobel gradients and the squared-magnitude threshold
// test that gives the output level.
// ----------------------------------------------------------------------------
module sebin_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  sebin_pkg::sebin_col_type    col_in,
   input  logic [sebin_pkg::THR_W-1:0] edge_thr,
   input  logic                        interior,
   output logic [sebin_pkg::PIX_W-1:0] level
);

   localparam int PW = sebin_pkg::PIX_W;
   localparam int GW = sebin_pkg::GRAD_W;
   localparam int MW = sebin_pkg::MAG_W;

   // win_ff[row*3+col], row 0 top, col 0 left (oldest)
   logic [PW-1:0]       win_ff [9];
   logic [GW-2:0]       right_sum, left_sum, bot_sum, top_sum;
   logic signed [GW-1:0] gx, gy;
   logic signed [2*GW-1:0] gx_sq, gy_sq;
   logic [MW-1:0]       mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= col_in.top;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= col_in.mid;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= col_in.bot;
      end
   end

   always_comb begin
      right_sum = (GW-1)'(win_ff[2]) + {win_ff[5], 1'b0} + (GW-1)'(win_ff[8]);
      left_sum  = (GW-1)'(win_ff[0]) + {win_ff[3], 1'b0} + (GW-1)'(win_ff[6]);
      bot_sum   = (GW-1)'(win_ff[6]) + {win_ff[7], 1'b0} + (GW-1)'(win_ff[8]);
      top_sum   = (GW-1)'(win_ff[0]) + {win_ff[1], 1'b0} + (GW-1)'(win_ff[2]);
      gx        = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      gy        = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
      gx_sq     = gx * gx;
      gy_sq     = gy * gy;
      mag       = gx_sq[MW-1:0] + gy_sq[MW-1:0];
      level     = (interior && (mag >= edge_thr)) ? sebin_pkg::LEVEL_EDGE
                                                  : sebin_pkg::LEVEL_WHITE;
   end

endmodule

// File: rtl/core/sobel_edge_binarizer_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_binarizer_unit
// Streaming 3x3 Sobel edge detector on RGB raster pixels with a binary
// output: 0 on edges, 255 elsewhere.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel per clock in raster order and returns one
// binary level per pixel, 0 where the squared Sobel magnitude of the grey
// image reaches the EDGE_THR register and 255 elsewhere; the outer ring of the
// frame is always 255. A result belongs to the pixel one row plus one pixel
// before the one that produced it, so after the last pixel of a frame send
// flush items (one row plus one) to drain the trailing border; frame_end
// marks the last result of a frame. The pipeline is three registers deep
// (input stage with the line-store read, window stage, output register),
// and a new item is taken every clock unless the output is held by rsp_stall.
// The two line stores sit in one MAX_WIDTH x 16 memory with one read and one
// write per clock; they need no clearing after reset. Width is clamped to
// [3, MAX_WIDTH], height to at least 3. Write the registers only while the
// block is idle.
// ----------------------------------------------------------------------------
module sobel_edge_binarizer_unit #(
   parameter int MAX_WIDTH = sebin_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sebin_pkg::PIX_W-1:0]      req_red,
   input  logic [sebin_pkg::PIX_W-1:0]      req_green,
   input  logic [sebin_pkg::PIX_W-1:0]      req_blue,
   input  logic                             req_flush,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sebin_pkg::PIX_W-1:0]      rsp_level,
   output logic                             rsp_frame_end,
   // register writes
   input  logic                             csr_write,
   input  logic [sebin_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sebin_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW      = sebin_pkg::PIX_W;
   localparam int FW      = sebin_pkg::FW_W;
   localparam int FH      = sebin_pkg::FH_W;
   localparam int TW      = sebin_pkg::THR_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W  = (WIDTH_W > FW) ? WIDTH_W : FW;
   localparam int CNT_W   = WIDTH_W + 1;
   localparam int TOTAL_W = $clog2(MAX_WIDTH * ((2 ** FH) - 1) + 1);
   localparam int PROD_W  = WIDTH_W + FH;
   localparam int SW      = sebin_pkg::SUM_W;

   // ---------------- configuration ----------------
   logic [FW-1:0]      frame_width_ff, frame_width_in;
   logic [FH-1:0]      frame_height_ff, frame_height_in;
   logic [TW-1:0]      edge_thr_ff, edge_thr_in;
   logic [WIDTH_W-1:0] width_eff_ff, width_eff_in;
   logic [FH-1:0]      height_eff_ff, height_eff_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [WCMP_W-1:0]  width_clamp;
   logic [PROD_W-1:0]  total_prod;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      edge_thr_in     = edge_thr_ff;
      if (csr_write) begin
         unique case (csr_index)
            sebin_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[FW-1:0];
            sebin_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[FH-1:0];
            sebin_pkg::CSR_EDGE_THR:     edge_thr_in     = csr_wdata[TW-1:0];
            default: ;
         endcase
      end
      width_clamp = WCMP_W'(frame_width_in);
      if (width_clamp < WCMP_W'(sebin_pkg::MIN_DIM)) begin
         width_clamp = WCMP_W'(sebin_pkg::MIN_DIM);
      end
      if (width_clamp > WCMP_W'(MAX_WIDTH)) begin
         width_clamp = WCMP_W'(MAX_WIDTH);
      end
      width_eff_in  = width_clamp[WIDTH_W-1:0];
      height_eff_in = (frame_height_in < FH'(sebin_pkg::MIN_DIM)) ?
                      FH'(sebin_pkg::MIN_DIM) : frame_height_in;
      total_prod    = PROD_W'(width_eff_in) * PROD_W'(height_eff_in);
      total_in      = total_prod[TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sebin_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= sebin_pkg::FRAME_HEIGHT_RESET;
         edge_thr_ff     <= sebin_pkg::EDGE_THR_RESET;
         width_eff_ff    <= WIDTH_W'(sebin_pkg::FRAME_WIDTH_RESET);
         height_eff_ff   <= sebin_pkg::FRAME_HEIGHT_RESET;
         total_ff        <= TOTAL_W'(PROD_W'(sebin_pkg::FRAME_WIDTH_RESET) *
                                     PROD_W'(sebin_pkg::FRAME_HEIGHT_RESET));
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         edge_thr_ff     <= edge_thr_in;
         width_eff_ff    <= width_eff_in;
         height_eff_ff   <= height_eff_in;
         total_ff        <= total_in;
      end
   end

   // ---------------- pipeline handshake ----------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_free, s1_adv, s2_adv, req_accept;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign s2_free    = ~s2_valid_ff | out_free;
   assign s1_adv     = s1_valid_ff & s2_free;
   assign s2_adv     = s2_valid_ff & out_free;
   assign req_stall  = s1_valid_ff & ~s2_free;
   assign req_accept = req_valid & ~req_stall;

   // ---------------- raster position and result bookkeeping ----------------
   logic [COL_W-1:0]   col_ff, col_in;
   logic [FH-1:0]      row_ff, row_in;
   logic [TOTAL_W-1:0] emitted_ff, emitted_in;
   logic               at_origin, col_nz, pixel;
   logic               emit_in, interior_in, frame_end_in;
   logic [FH-1:0]      er;
   logic [COL_W-1:0]   ec;
   logic [WIDTH_W-1:0] width_m1;
   logic [CNT_W-1:0]   col_inc;
   logic [FH:0]        row_inc;
   logic [TOTAL_W-1:0] emitted_base;
   logic [TOTAL_W:0]   emitted_inc;

   always_comb begin
      pixel     = ~req_flush;
      at_origin = (row_ff == '0) && (col_ff == '0);
      col_nz    = (col_ff != '0);
      width_m1  = width_eff_ff - WIDTH_W'(1);

      // which pixel the result belongs to: one row plus one pixel back
      if (col_nz) begin
         er = row_ff - FH'(1);
         ec = col_ff - COL_W'(1);
      end else begin
         er = (row_ff >= FH'(2)) ? row_ff - FH'(2) : '0;
         ec = width_m1[COL_W-1:0];
      end
      interior_in = pixel && (er != '0) && (ec != '0) &&
                    ((FH + 1)'(er) + (FH + 1)'(2) <= (FH + 1)'(height_eff_ff)) &&
                    (CNT_W'(ec) + CNT_W'(2) <= CNT_W'(width_eff_ff));

      if (pixel) begin
         emit_in = (row_ff >= FH'(2)) || ((row_ff == FH'(1)) && col_nz);
      end else begin
         // flush drains trailing border results only after a whole frame went in
         emit_in = at_origin && (emitted_ff != '0);
      end

      // a new frame drops any trailing results still pending
      emitted_base = (pixel && at_origin) ? '0 : emitted_ff;
      emitted_inc  = (TOTAL_W + 1)'(emitted_base) + (TOTAL_W + 1)'(1);
      frame_end_in = emit_in && (emitted_inc >= (TOTAL_W + 1)'(total_ff));
      if (!emit_in) begin
         emitted_in = emitted_base;
      end else if (frame_end_in) begin
         emitted_in = '0;
      end else begin
         emitted_in = emitted_inc[TOTAL_W-1:0];
      end

      col_inc = CNT_W'(col_ff) + CNT_W'(1);
      row_inc = (FH + 1)'(row_ff) + (FH + 1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (pixel) begin
         if (col_inc >= CNT_W'(width_eff_ff)) begin
            col_in = '0;
            row_in = (row_inc >= (FH + 1)'(height_eff_ff)) ? '0 : row_inc[FH-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         emitted_ff <= '0;
      end else if (req_accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         emitted_ff <= emitted_in;
      end
   end

   // ---------------- stage 1: input register, line-store read ----------------
   logic             s1_flush_ff, s1_emit_ff, s1_interior_ff, s1_frame_end_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PW-1:0]    s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [PW-1:0]    rd_top, rd_mid, grey;
   logic [SW-1:0]    rgb_sum;
   logic [2*SW-1:0]  grey_prod;
   logic             px_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flush_ff     <= req_flush;
         s1_emit_ff      <= emit_in;
         s1_interior_ff  <= interior_in;
         s1_frame_end_ff <= frame_end_in;
         s1_col_ff       <= col_ff;
         s1_red_ff       <= req_red;
         s1_green_ff     <= req_green;
         s1_blue_ff      <= req_blue;
      end
   end

   always_comb begin
      rgb_sum   = SW'(s1_red_ff) + SW'(s1_green_ff) + SW'(s1_blue_ff);
      grey_prod = (2 * SW)'(rgb_sum) * (2 * SW)'(sebin_pkg::GREY_RECIP);
      grey      = grey_prod[sebin_pkg::GREY_SHIFT +: PW];
   end

   assign px_adv = s1_adv & ~s1_flush_ff;

   sebin_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_top  (rd_top),
      .rd_mid  (rd_mid),
      .wr_en   (px_adv),
      .wr_addr (s1_col_ff),
      .wr_top  (rd_mid),
      .wr_mid  (grey)
   );

   // ---------------- stage 2: window and threshold ----------------
   logic                     s2_interior_ff, s2_frame_end_ff;
   sebin_pkg::sebin_col_type new_col;
   logic [PW-1:0]            level;

   assign new_col.top = rd_top;
   assign new_col.mid = rd_mid;
   assign new_col.bot = grey;

   sebin_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (px_adv),
      .col_in   (new_col),
      .edge_thr (edge_thr_ff),
      .interior (s2_interior_ff),
      .level    (level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_emit_ff;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_interior_ff  <= s1_interior_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
   end

   // ---------------- output register ----------------
   logic [PW-1:0] rsp_level_ff;
   logic          rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_level_ff     <= level;
         rsp_frame_end_ff <= s2_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Sobel edge binarizer unit.
// ----------------------------------------------------------------------------
// RGB pixel frames are streamed through the block. The bench keeps its own
// line stores, 3x3 window and frame counters and works out the expected
// binary level and frame_end marker of every result that a pixel or flush yields. Each
// result that comes back is compared against the oldest expected one.
// Directed frames cover extreme pixel values, a zero threshold, the exact
// threshold boundary and flushes at odd moments. Random frames of many sizes
// and thresholds follow, with clamped widths and heights, dropped trailing
// results, mid-frame flushes and random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 4;

   localparam int PW   = sebin_pkg::PIX_W;
   localparam int CDW  = sebin_pkg::CSR_DATA_W;
   localparam int MAXW = sebin_pkg::MAX_WIDTH_DEFAULT;
   localparam int MIND = sebin_pkg::MIN_DIM;

   typedef enum int unsigned {
      TEXTURE_NOISE,
      TEXTURE_GREY,
      TEXTURE_SMOOTH,
      TEXTURE_BINARY
   } texture_type;

   typedef struct packed {
      logic [PW-1:0] level;
      logic          frame_end;
   } level_item_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [PW-1:0]                    req_red;
   logic [PW-1:0]                    req_green;
   logic [PW-1:0]                    req_blue;
   logic                             req_flush;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [PW-1:0]                    rsp_level;
   logic                             rsp_frame_end;
   logic                             csr_write;
   sebin_pkg::csr_index_type         csr_index;
   logic [CDW-1:0]                   csr_wdata;

   bit gaps_on;
   bit stalls_on;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned useful_items = 0;

   // predictor state
   logic [sebin_pkg::FW_W-1:0]  width_reg  = sebin_pkg::FRAME_WIDTH_RESET;
   logic [sebin_pkg::FH_W-1:0]  height_reg = sebin_pkg::FRAME_HEIGHT_RESET;
   logic [sebin_pkg::THR_W-1:0] thr_reg    = sebin_pkg::EDGE_THR_RESET;
   logic [PW-1:0]    prev_row   [MAXW];
   logic [PW-1:0]    older_row  [MAXW];
   logic [PW-1:0]    window_pix [9];
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   int unsigned      emit_cnt = 0;
   level_item_type   pending_levels[$];

   sobel_edge_binarizer_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_flush     (req_flush),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_frame_end (rsp_frame_end),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= stalls_on && ($urandom_range(99) < 19);
   end

   always @(posedge clock) begin : check_levels
      level_item_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result: expected none, got level %0d frame_end %0b",
                     $time, rsp_level, rsp_frame_end);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_level !== want.level) begin
               $display("%0t: level mismatch: expected %0d, got %0d",
                        $time, want.level, rsp_level);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end mismatch: expected %0b, got %0b",
                        $time, want.frame_end, rsp_frame_end);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int unsigned active_width();
      int unsigned w;
      w = 32'(width_reg);
      if (w < MIND) return MIND;
      if (w > MAXW) return MAXW;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < MIND) return MIND;
      return h;
   endfunction

   function automatic logic [CDW-1:0] pick_threshold();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 21'd2080800;
         default: return CDW'($urandom_range(120000));
      endcase
   endfunction

   task automatic push_level(input logic [PW-1:0] lvl);
      level_item_type item;
      item.level     = lvl;
      item.frame_end = 1'b0;
      emit_cnt++;
      if (emit_cnt >= active_width() * active_height()) begin
         emit_cnt       = 0;
         item.frame_end = 1'b1;
      end
      pending_levels.push_back(item);
   endtask

   // Advance the frame state by one accepted item and queue its result, if it has one.
   task automatic binarize_item(input logic [PW-1:0] red, green, blue,
                                input logic flush);
      int unsigned w, h, r, c, er, ec, grey, mag;
      int          p[9];
      int          gx, gy;
      logic [PW-1:0] top, mid, lvl;
      bit          emit, interior;
      w = active_width();
      h = active_height();
      r = row_pos;
      c = col_pos;
      if (flush) begin
         // trailing border results only once the frame is complete
         if (r == 0 && c == 0 && emit_cnt != 0) begin
            useful_items++;
            push_level(sebin_pkg::LEVEL_WHITE);
         end
         return;
      end
      useful_items++;
      if (r == 0 && c == 0) emit_cnt = 0;
      grey = (32'(red) + 32'(green) + 32'(blue)) / 3;
      top = older_row[c];
      mid = prev_row[c];
      older_row[c] = mid;
      prev_row[c]  = grey[PW-1:0];
      window_pix[0] = window_pix[1];
      window_pix[1] = window_pix[2];
      window_pix[3] = window_pix[4];
      window_pix[4] = window_pix[5];
      window_pix[6] = window_pix[7];
      window_pix[7] = window_pix[8];
      window_pix[2] = top;
      window_pix[5] = mid;
      window_pix[8] = grey[PW-1:0];
      emit = (r >= 2) || (r == 1 && c >= 1);
      // the result belongs to the window center, one row plus one pixel back
      if (c >= 1) begin
         er = r - 1;
         ec = c - 1;
      end else begin
         er = (r >= 2) ? r - 2 : 0;
         ec = w - 1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      if (!emit) return;
      interior = er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w;
      lvl = sebin_pkg::LEVEL_WHITE;
      if (interior) begin
         for (int i = 0; i < 9; i++) p[i] = int'(window_pix[i]);
         gx  = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
         gy  = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
         mag = unsigned'(gx * gx + gy * gy);
         if (mag >= 32'(thr_reg)) lvl = sebin_pkg::LEVEL_EDGE;
      end
      push_level(lvl);
   endtask

   task automatic send_item(input logic [PW-1:0] red, green, blue,
                            input logic flush);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         req_red   = PW'($urandom_range(255));
         req_flush = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_red   = red;
      req_green = green;
      req_blue  = blue;
      req_flush = flush;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      binarize_item(red, green, blue, flush);
   endtask

   task automatic send_flush();
      send_item(PW'($urandom_range(255)), PW'($urandom_range(255)),
                PW'($urandom_range(255)), 1'b1);
   endtask

   // Stop sending and let every expected result come out of the pipeline.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input sebin_pkg::csr_index_type idx,
                            input logic [CDW-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         sebin_pkg::CSR_FRAME_WIDTH:  width_reg  = value[sebin_pkg::FW_W-1:0];
         sebin_pkg::CSR_FRAME_HEIGHT: height_reg = value[sebin_pkg::FH_W-1:0];
         default:                     thr_reg    = value[sebin_pkg::THR_W-1:0];
      endcase
   endtask

   task automatic drain_trailing();
      while (emit_cnt != 0) send_flush();
   endtask

   task automatic send_frame_pixels(input texture_type texture, input int unsigned count);
      int unsigned base;
      logic [PW-1:0] r, g, b;
      base = $urandom_range(255);
      for (int unsigned k = 0; k < count; k++) begin
         case (texture)
            TEXTURE_NOISE: begin
               r = PW'($urandom_range(255));
               g = PW'($urandom_range(255));
               b = PW'($urandom_range(255));
            end
            TEXTURE_GREY: begin
               r = PW'($urandom_range(255));
               g = r;
               b = r;
            end
            TEXTURE_SMOOTH: begin
               base = (base + $urandom_range(2)) % 256;
               r = PW'(base);
               g = PW'(base);
               b = PW'(base) ^ PW'($urandom_range(1));
            end
            default: begin
               r = ($urandom_range(1) != 0) ? sebin_pkg::LEVEL_WHITE
                                            : sebin_pkg::LEVEL_EDGE;
               g = r;
               b = r;
            end
         endcase
         // a flush while the frame is incomplete must do nothing
         if (k != 0 && $urandom_range(24) == 0) send_flush();
         send_item(r, g, b, 1'b0);
      end
   endtask

   task automatic run_random_frame();
      logic [CDW-1:0] w;
      // registers change only when no trailing results are left behind
      if (emit_cnt == 0) begin
         settle();
         if ($urandom_range(1)) begin
            case ($urandom_range(9))
               0:       w = CDW'($urandom_range(2));
               1:       w = CDW'($urandom_range(40, 13));
               default: w = CDW'($urandom_range(12, 3));
            endcase
            write_csr(sebin_pkg::CSR_FRAME_WIDTH, w);
         end
         if ($urandom_range(1)) begin
            write_csr(sebin_pkg::CSR_FRAME_HEIGHT, CDW'($urandom_range(8)));
         end
         if ($urandom_range(1)) write_csr(sebin_pkg::CSR_EDGE_THR, pick_threshold());
      end
      send_frame_pixels(texture_type'($urandom_range(3)), active_width() * active_height());
      if ($urandom_range(5) == 0) begin
         // next frame starts before the border is fully flushed
         repeat ($urandom_range(active_width())) send_flush();
      end else begin
         drain_trailing();
         repeat ($urandom_range(2)) send_flush();
      end
   endtask

   task automatic test_flush_after_reset();
      send_flush();
      settle();
   endtask

   task automatic test_small_frame_extremes();
      write_csr(sebin_pkg::CSR_FRAME_WIDTH, 21'd3);
      write_csr(sebin_pkg::CSR_FRAME_HEIGHT, 21'd3);
      write_csr(sebin_pkg::CSR_EDGE_THR, 21'd0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd255, 8'd255, 8'd254, 1'b0);
      send_item(8'd0, 8'd0, 8'd1, 1'b0);
      send_flush();
      send_item(8'd255, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd255, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd255, 1'b0);
      send_item(8'd170, 8'd85, 8'd1, 1'b0);
      send_item(8'd128, 8'd127, 8'd2, 1'b0);
      drain_trailing();
      send_flush();
      settle();
   endtask

   // Window giving gx = 1020, gy = 510: magnitude exactly on the threshold.
   task automatic test_gradient_boundary();
      write_csr(sebin_pkg::CSR_EDGE_THR, 21'd1300500);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      drain_trailing();
      settle();
   endtask

   // Width above the maximum, clamped; only the start of the first row is
   // sent and the frame stays open for the tall frame that follows.
   task automatic test_wide_frames();
      write_csr(sebin_pkg::CSR_FRAME_WIDTH, 21'd2047);
      write_csr(sebin_pkg::CSR_FRAME_HEIGHT, 21'd1);
      write_csr(sebin_pkg::CSR_EDGE_THR, pick_threshold());
      send_frame_pixels(texture_type'($urandom_range(3)), 100);
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned goal;
      goal = useful_items + 300;
      while (useful_items < goal) run_random_frame();
      drain_trailing();
      settle();
   endtask

   task automatic test_steady_stream();
      int unsigned goal;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      goal = useful_items + 120;
      while (useful_items < goal) run_random_frame();
      drain_trailing();
      settle();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // Tallest frame allowed, entered partway through the open wide row, so the
   // column wraps at the new width; only its first rows are sent.
   task automatic test_tall_frame();
      write_csr(sebin_pkg::CSR_FRAME_WIDTH, 21'd3);
      write_csr(sebin_pkg::CSR_FRAME_HEIGHT, 21'd65535);
      write_csr(sebin_pkg::CSR_EDGE_THR, pick_threshold());
      send_frame_pixels(texture_type'($urandom_range(3)), 90);
      settle();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      req_flush = 1'b0;
      csr_write = 1'b0;
      csr_index = sebin_pkg::CSR_FRAME_WIDTH;
      csr_wdata = '0;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (int i = 0; i < MAXW; i++) begin
         prev_row[i]  = '0;
         older_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) window_pix[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_flush_after_reset();
      test_small_frame_extremes();
      test_gradient_boundary();
      test_random_frames();
      test_steady_stream();
      test_wide_frames();
      test_tall_frame();

      if (mismatch_count == 0 && pending_levels.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
